### src/rmcg_pkg.sv
// Shared types, constants and relay update functions for the relay guard.
`default_nettype none
package rmcg_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned SpanW  = 31;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [SpanW-1:0] RstPumpMaxOn    = SpanW'(60000);
  localparam logic [SpanW-1:0] RstPumpCooldown = SpanW'(10000);
  localparam logic [SpanW-1:0] RstFanMaxOn     = SpanW'(1800000);
  localparam logic [SpanW-1:0] RstFanCooldown  = SpanW'(10000);

  typedef enum logic [CmdW-1:0] {
    CMD_PUMP    = 2'd0,
    CMD_FAN     = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_RESTORE = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SELF_TEST     = 3'd0,
    REG_AUTO_SAFETY   = 3'd1,
    REG_PUMP_MAX_ON   = 3'd2,
    REG_PUMP_COOLDOWN = 3'd3,
    REG_FAN_MAX_ON    = 3'd4,
    REG_FAN_COOLDOWN  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic             on;
    logic [TimeW-1:0] since;
    logic [TimeW-1:0] cool_end;
  } relay_t;

  // Result of a request: the updated relay and whether it was refused.
  typedef struct packed {
    relay_t relay;
    logic   reject;
  } req_res_t;

  typedef struct packed {
    relay_t relay;
    logic   timed_out;
  } tick_res_t;

  function automatic req_res_t relay_request(relay_t r, logic self_test, logic on,
                                             logic [TimeW-1:0] now,
                                             logic [SpanW-1:0] cooldown);
    req_res_t         res;
    logic [TimeW-1:0] diff;
    diff = now - r.cool_end;
    res.relay  = r;
    res.reject = 1'b0;
    if (!self_test && on && diff[TimeW-1]) begin
      res.reject = 1'b1;
    end else if (on) begin
      res.relay.on    = 1'b1;
      res.relay.since = now;
    end else begin
      if (!self_test && r.on) begin
        res.relay.cool_end = now + {1'b0, cooldown};
      end
      res.relay.since = '0;
      res.relay.on    = 1'b0;
    end
    return res;
  endfunction

  function automatic tick_res_t relay_tick(relay_t r, logic [TimeW-1:0] now,
                                           logic [SpanW-1:0] max_on,
                                           logic [SpanW-1:0] cooldown);
    tick_res_t        res;
    logic [TimeW-1:0] elapsed;
    elapsed = now - r.since;
    res.relay     = r;
    res.timed_out = 1'b0;
    // An on-since of zero marks a relay that is not being timed.
    if (r.on && (r.since != '0) && !elapsed[TimeW-1] && (elapsed >= {1'b0, max_on})) begin
      res.relay.on       = 1'b0;
      res.relay.since    = '0;
      res.relay.cool_end = now + {1'b0, cooldown};
      res.timed_out      = 1'b1;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### src/rmcg_req_if.sv
// Input item channel: command, switch_on and timestamp with valid/ready.
`default_nettype none
interface rmcg_req_if;
  logic                          valid;
  logic                          ready;
  logic [rmcg_pkg::CmdW-1:0]     command;
  logic                          switch_on;
  logic [rmcg_pkg::TimeW-1:0]    now_ms;

  modport source (output valid, command, switch_on, now_ms, input ready);
  modport sink   (input valid, command, switch_on, now_ms, output ready);
endinterface
`default_nettype wire

### src/rmcg_rsp_if.sv
// Result item channel: status and relay states with valid/ready.
`default_nettype none
interface rmcg_rsp_if;
  logic valid;
  logic ready;
  logic status;
  logic pump_on;
  logic fan_on;
  logic pump_timed_out;
  logic fan_timed_out;

  modport source (output valid, status, pump_on, fan_on, pump_timed_out, fan_timed_out,
                  input ready);
  modport sink   (input valid, status, pump_on, fan_on, pump_timed_out, fan_timed_out,
                  output ready);
endinterface
`default_nettype wire

### src/rmcg_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
`default_nettype none
interface rmcg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rmcg_pkg::CfgIdxW-1:0]    index;
  logic [rmcg_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/relay_max_on_cooldown_guard.sv
// Top level of the pump and fan relay guard with max-on timeouts and cooldowns.
`default_nettype none
// The guard takes one item per clock while the output is not stalled and returns
// one result item for each: the item is captured in an input register, the relay
// state and result are computed by short compare/add logic and are registered in
// the result register, from which the result is offered on the result channel.
// Both stages advance whenever the result register is empty or being taken, so a
// stalled output holds at most two items and throughput is one item per cycle
// when the sink is always ready.
// Configuration writes are taken every cycle and should only be made while idle.
module relay_max_on_cooldown_guard (
  input  logic        clk,
  input  logic        rst,
  rmcg_cfg_if.sink    cfg,
  rmcg_req_if.sink    req,
  rmcg_rsp_if.source  rsp
);

  // Configuration registers.
  logic                             self_test;
  logic                             auto_safety;
  logic [rmcg_pkg::SpanW-1:0]       pump_max_on;
  logic [rmcg_pkg::SpanW-1:0]       pump_cooldown;
  logic [rmcg_pkg::SpanW-1:0]       fan_max_on;
  logic [rmcg_pkg::SpanW-1:0]       fan_cooldown;

  // Relay state.
  rmcg_pkg::relay_t pump;
  rmcg_pkg::relay_t fan;
  rmcg_pkg::relay_t pump_next;
  rmcg_pkg::relay_t fan_next;

  // Input register.
  logic                          in_valid;
  rmcg_pkg::cmd_t                in_cmd;
  logic                          in_on;
  logic [rmcg_pkg::TimeW-1:0]    in_now;

  // Result register.
  logic out_valid;
  logic out_status;
  logic out_pump_to;
  logic out_fan_to;
  logic status_next;
  logic pump_to_next;
  logic fan_to_next;

  logic advance;
  logic work;

  rmcg_pkg::req_res_t  pump_req;
  rmcg_pkg::req_res_t  fan_req;
  rmcg_pkg::tick_res_t pump_tick;
  rmcg_pkg::tick_res_t fan_tick;

  assign advance   = !out_valid || rsp.ready;
  assign work      = in_valid && advance;
  assign req.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.pump_on        = pump.on;
  assign rsp.fan_on         = fan.on;
  assign rsp.pump_timed_out = out_pump_to;
  assign rsp.fan_timed_out  = out_fan_to;

  always_ff @(posedge clk) begin
    if (rst) begin
      self_test     <= 1'b0;
      auto_safety   <= 1'b1;
      pump_max_on   <= rmcg_pkg::RstPumpMaxOn;
      pump_cooldown <= rmcg_pkg::RstPumpCooldown;
      fan_max_on    <= rmcg_pkg::RstFanMaxOn;
      fan_cooldown  <= rmcg_pkg::RstFanCooldown;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rmcg_pkg::REG_SELF_TEST:     self_test     <= cfg.data[0];
        rmcg_pkg::REG_AUTO_SAFETY:   auto_safety   <= cfg.data[0];
        rmcg_pkg::REG_PUMP_MAX_ON:   pump_max_on   <= cfg.data[rmcg_pkg::SpanW-1:0];
        rmcg_pkg::REG_PUMP_COOLDOWN: pump_cooldown <= cfg.data[rmcg_pkg::SpanW-1:0];
        rmcg_pkg::REG_FAN_MAX_ON:    fan_max_on    <= cfg.data[rmcg_pkg::SpanW-1:0];
        rmcg_pkg::REG_FAN_COOLDOWN:  fan_cooldown  <= cfg.data[rmcg_pkg::SpanW-1:0];
        default: ;
      endcase
    end
  end

  assign pump_req  = rmcg_pkg::relay_request(pump, self_test, in_on, in_now, pump_cooldown);
  assign fan_req   = rmcg_pkg::relay_request(fan, self_test, in_on, in_now, fan_cooldown);
  assign pump_tick = rmcg_pkg::relay_tick(pump, in_now, pump_max_on, pump_cooldown);
  assign fan_tick  = rmcg_pkg::relay_tick(fan, in_now, fan_max_on, fan_cooldown);

  always_comb begin
    pump_next    = pump;
    fan_next     = fan;
    status_next  = 1'b0;
    pump_to_next = 1'b0;
    fan_to_next  = 1'b0;
    unique case (in_cmd)
      rmcg_pkg::CMD_PUMP: begin
        pump_next   = pump_req.relay;
        status_next = pump_req.reject;
      end
      rmcg_pkg::CMD_FAN: begin
        fan_next    = fan_req.relay;
        status_next = fan_req.reject;
      end
      rmcg_pkg::CMD_TICK: begin
        // The pump timeout only runs with auto safety enabled.
        if (auto_safety) begin
          pump_next    = pump_tick.relay;
          pump_to_next = pump_tick.timed_out;
        end
        fan_next    = fan_tick.relay;
        fan_to_next = fan_tick.timed_out;
      end
      rmcg_pkg::CMD_RESTORE: begin
        pump_next = '0;
        fan_next  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      pump      <= '0;
      fan       <= '0;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (work) begin
        pump <= pump_next;
        fan  <= fan_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_cmd <= rmcg_pkg::cmd_t'(req.command);
      in_on  <= req.switch_on;
      in_now <= req.now_ms;
    end
    if (work) begin
      out_status  <= status_next;
      out_pump_to <= pump_to_next;
      out_fan_to  <= fan_to_next;
    end
  end

endmodule
`default_nettype wire

### tb/relay_max_on_cooldown_guard_tb.sv
// Self-checking testbench for the pump and fan relay guard.
`timescale 1ns / 100ps
module relay_max_on_cooldown_guard_tb;
  import rmcg_pkg::*;

  localparam int StallLimit    = 1000;
  localparam int SettleCycles  = 8;
  localparam int Phases        = 8;
  localparam int ItemsPerPhase = 115;
  localparam logic [SpanW-1:0] SpanMax = 31'h7FFF_FFFF;
  localparam logic [CfgIdxW-1:0] SpareRegLo = 3'd6;
  localparam logic [CfgIdxW-1:0] SpareRegHi = 3'd7;

  typedef enum int {PHASE_SMALL, PHASE_EXTREME, PHASE_WIDE} phase_kind_t;
  typedef enum int {SINK_ALWAYS, SINK_TWO_OF_THREE, SINK_ONE_OF_FOUR, SINK_COIN} sink_mode_t;

  typedef struct packed {
    logic             on;
    logic [TimeW-1:0] since;
    logic [TimeW-1:0] cool_end;
  } relay_track_t;

  typedef struct packed {
    logic status;
    logic pump_on;
    logic fan_on;
    logic pump_timed_out;
    logic fan_timed_out;
  } relay_report_t;

  logic clk;
  logic rst;

  rmcg_cfg_if cfg ();
  rmcg_req_if req ();
  rmcg_rsp_if rsp ();

  relay_max_on_cooldown_guard DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  // Guard state as the testbench tracks it.
  relay_track_t     pump_trk;
  relay_track_t     fan_trk;
  logic             self_test_cfg;
  logic             auto_safety_cfg;
  logic [SpanW-1:0] pump_max_on_cfg;
  logic [SpanW-1:0] pump_cool_cfg;
  logic [SpanW-1:0] fan_max_on_cfg;
  logic [SpanW-1:0] fan_cool_cfg;

  relay_report_t    pending_reports[$];
  relay_report_t    want;
  logic [TimeW-1:0] clock_ms;

  int fail_count;
  int items_sent;
  int reports_checked;
  int rejects_seen;
  int pump_timeouts;
  int fan_timeouts;
  int cfg_writes;
  int phase_count;
  int idle_cycles;
  int sink_left;
  int sink_tick;
  sink_mode_t sink_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic relay_request(inout relay_track_t r, input logic [SpanW-1:0] cool,
                                         input logic on, input logic [TimeW-1:0] now);
    logic [TimeW-1:0] diff;
    logic             refused;
    diff    = now - r.cool_end;
    refused = !self_test_cfg && on && diff[TimeW-1];
    if (!refused) begin
      if (on) begin
        r.since = now;
      end else begin
        if (!self_test_cfg && r.on) begin
          r.cool_end = now + {1'b0, cool};
        end
        r.since = '0;
      end
      r.on = on;
    end
    return refused;
  endfunction

  function automatic logic relay_tick(inout relay_track_t r, input logic [SpanW-1:0] max_on,
                                      input logic [SpanW-1:0] cool,
                                      input logic [TimeW-1:0] now);
    logic [TimeW-1:0] elapsed;
    logic             expired;
    elapsed = now - r.since;
    // A relay switched on at time zero carries since = 0 and is never timed.
    expired = r.on && (r.since != '0) && !elapsed[TimeW-1] && (elapsed >= {1'b0, max_on});
    if (expired) begin
      r.on       = 1'b0;
      r.since    = '0;
      r.cool_end = now + {1'b0, cool};
    end
    return expired;
  endfunction

  function automatic relay_report_t predict_relay_report(input cmd_t cmd, input logic on,
                                                         input logic [TimeW-1:0] now);
    relay_report_t rep;
    rep = '0;
    case (cmd)
      CMD_PUMP: rep.status = relay_request(pump_trk, pump_cool_cfg, on, now);
      CMD_FAN:  rep.status = relay_request(fan_trk, fan_cool_cfg, on, now);
      CMD_TICK: begin
        if (auto_safety_cfg) begin
          rep.pump_timed_out = relay_tick(pump_trk, pump_max_on_cfg, pump_cool_cfg, now);
        end
        rep.fan_timed_out = relay_tick(fan_trk, fan_max_on_cfg, fan_cool_cfg, now);
      end
      default: begin
        pump_trk = '0;
        fan_trk  = '0;
      end
    endcase
    rep.pump_on = pump_trk.on;
    rep.fan_on  = fan_trk.on;
    return rep;
  endfunction

  function automatic logic [SpanW-1:0] pick_span(input phase_kind_t kind);
    logic [SpanW-1:0] span;
    case (kind)
      PHASE_SMALL: span = SpanW'($urandom_range(0, 400));
      PHASE_WIDE:  span = SpanW'($urandom_range(5000, 70000));
      default: begin
        case ($urandom_range(0, 3))
          0:       span = '0;
          1:       span = SpanW'(1);
          2:       span = SpanMax - SpanW'(1);
          default: span = SpanMax;
        endcase
      end
    endcase
    return span;
  endfunction

  task automatic send_command(input cmd_t cmd, input logic on, input logic [TimeW-1:0] now);
    @(negedge clk);
    req.valid     <= 1'b1;
    req.command   <= cmd;
    req.switch_on <= on;
    req.now_ms    <= now;
    do @(posedge clk); while (req.ready !== 1'b1);
    pending_reports.push_back(predict_relay_report(cmd, on, now));
    items_sent++;
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk);
    req.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    req.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    case (idx)
      REG_SELF_TEST:     self_test_cfg   = value[0];
      REG_AUTO_SAFETY:   auto_safety_cfg = value[0];
      REG_PUMP_MAX_ON:   pump_max_on_cfg = value[SpanW-1:0];
      REG_PUMP_COOLDOWN: pump_cool_cfg   = value[SpanW-1:0];
      REG_FAN_MAX_ON:    fan_max_on_cfg  = value[SpanW-1:0];
      REG_FAN_COOLDOWN:  fan_cool_cfg    = value[SpanW-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic release_cfg();
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Power-on settings: timeouts, cooldown rejects and restore.
  task automatic test_defaults();
    send_command(CMD_PUMP, 1'b1, 32'd1000);
    send_command(CMD_TICK, 1'b0, 32'd60999);
    send_command(CMD_TICK, 1'b1, 32'd61000);
    send_command(CMD_PUMP, 1'b1, 32'd65000);
    send_command(CMD_PUMP, 1'b1, 32'd71000);
    send_command(CMD_PUMP, 1'b0, 32'd72000);
    send_command(CMD_RESTORE, 1'b0, 32'd72000);
    send_command(CMD_FAN, 1'b1, 32'd72001);
    send_command(CMD_TICK, 1'b0, 32'd1872001);
    send_command(CMD_FAN, 1'b1, 32'd1874001);
  endtask

  // Zero on-since, counter wrap, time running backwards and the sign of elapsed time.
  task automatic test_edge_times();
    send_command(CMD_RESTORE, 1'b1, 32'hFFFF_FFFF);
    send_command(CMD_PUMP, 1'b1, 32'h0000_0000);
    send_command(CMD_TICK, 1'b1, 32'h7FFF_0000);
    send_command(CMD_PUMP, 1'b1, 32'hFFFF_FF00);
    send_command(CMD_TICK, 1'b0, 32'h0000_EB00);
    send_command(CMD_FAN, 1'b1, 32'hFFFF_FFF0);
    send_command(CMD_TICK, 1'b0, 32'hFFFF_FF00);
    send_command(CMD_TICK, 1'b1, 32'h7FFF_FFF0);
    send_command(CMD_PUMP, 1'b1, 32'h0000_EB01);
  endtask

  // Register extremes, masking of wide writes, spare indexes, safety off and self-test.
  task automatic test_config_extremes();
    wait_all_results();
    write_reg(REG_SELF_TEST, 32'hFFFF_FFFE);
    write_reg(REG_AUTO_SAFETY, 32'hFFFF_FFFE);
    write_reg(REG_PUMP_MAX_ON, 32'h0000_0000);
    write_reg(REG_PUMP_COOLDOWN, 32'hFFFF_FFFF);
    write_reg(REG_FAN_MAX_ON, 32'hFFFF_FFFF);
    write_reg(REG_FAN_COOLDOWN, 32'h0000_0000);
    write_reg(SpareRegLo, $urandom);
    write_reg(SpareRegHi, $urandom);
    release_cfg();
    send_command(CMD_RESTORE, 1'b0, 32'd50);
    send_command(CMD_PUMP, 1'b1, 32'd100);
    send_command(CMD_TICK, 1'b0, 32'd200);
    send_command(CMD_PUMP, 1'b0, 32'd300);
    send_command(CMD_FAN, 1'b1, 32'd400);
    send_command(CMD_TICK, 1'b1, 32'h8000_018F);
    wait_all_results();
    write_reg(REG_SELF_TEST, 32'h0000_0003);
    release_cfg();
    send_command(CMD_PUMP, 1'b1, 32'd500);
    send_command(CMD_PUMP, 1'b0, 32'd600);
  endtask

  task automatic program_phase(input phase_kind_t kind);
    wait_all_results();
    write_reg(REG_SELF_TEST, {31'($urandom), 1'($urandom_range(0, 3) == 0)});
    write_reg(REG_AUTO_SAFETY, {31'($urandom), 1'($urandom_range(0, 3) != 0)});
    write_reg(REG_PUMP_MAX_ON, {1'($urandom), pick_span(kind)});
    write_reg(REG_PUMP_COOLDOWN, {1'($urandom), pick_span(kind)});
    write_reg(REG_FAN_MAX_ON, {1'($urandom), pick_span(kind)});
    write_reg(REG_FAN_COOLDOWN, {1'($urandom), pick_span(kind)});
    if ($urandom_range(0, 1)) begin
      write_reg($urandom_range(0, 1) ? SpareRegLo : SpareRegHi, $urandom);
    end
    release_cfg();
    phase_count++;
  endtask

  task automatic send_random_item(input phase_kind_t kind);
    int               pick_cmd;
    int               pick_time;
    cmd_t             cmd;
    logic             on;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] offset;
    pick_cmd  = $urandom_range(0, 99);
    pick_time = $urandom_range(0, 99);
    on        = 1'($urandom_range(0, 1));
    offset    = TimeW'($urandom_range(0, 2)) - TimeW'(1);
    if (pick_cmd < 34) cmd = CMD_PUMP;
    else if (pick_cmd < 68) cmd = CMD_FAN;
    else if (pick_cmd < 96) cmd = CMD_TICK;
    else cmd = CMD_RESTORE;
    if (pick_time < 78) begin
      if (kind == PHASE_EXTREME && $urandom_range(0, 1)) begin
        clock_ms += $urandom;
      end else begin
        clock_ms += $urandom_range(0, (kind == PHASE_WIDE) ? 25000 : 150);
      end
      now = clock_ms;
    end else if (pick_time < 86) begin
      // Tick right at the edge of a relay's max-on time.
      cmd = CMD_TICK;
      if ($urandom_range(0, 1)) now = pump_trk.since + {1'b0, pump_max_on_cfg} + offset;
      else now = fan_trk.since + {1'b0, fan_max_on_cfg} + offset;
      clock_ms = now;
    end else if (pick_time < 94) begin
      now      = ($urandom_range(0, 1) ? pump_trk.cool_end : fan_trk.cool_end) + offset;
      clock_ms = now;
    end else begin
      now = $urandom;
    end
    send_command(cmd, on, now);
  endtask

  // Sessions of random requests and ticks under a fresh setting per phase.
  task automatic test_random_sessions();
    phase_kind_t kind;
    int          burst_left;
    logic        no_gaps;
    for (int p = 0; p < Phases; p++) begin
      if (p == 0) kind = PHASE_WIDE;
      else if (p == 1 || p == Phases - 1) kind = PHASE_EXTREME;
      else kind = phase_kind_t'($urandom_range(0, 2));
      program_phase(kind);
      no_gaps    = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (p == 2 && i == ItemsPerPhase / 2) begin
          wait_all_results();
        end
        if (!no_gaps) begin
          if (burst_left == 0) begin
            idle_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 16);
          end
          burst_left--;
        end
        send_random_item(kind);
      end
    end
  endtask

  // Result sink: stalls follow a mode that is drawn anew whenever its random run length is used up.
  initial begin
    rsp.ready = 1'b0;
    sink_left = 0;
    sink_tick = 0;
    sink_mode = SINK_ALWAYS;
    forever begin
      @(negedge clk);
      if (sink_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        sink_left = $urandom_range(20, 80);
      end
      sink_left--;
      sink_tick++;
      case (sink_mode)
        SINK_ALWAYS:       rsp.ready <= 1'b1;
        SINK_TWO_OF_THREE: rsp.ready <= (sink_tick % 3) != 0;
        SINK_ONE_OF_FOUR:  rsp.ready <= (sink_tick % 4) == 0;
        default:           rsp.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic check_bit(input string name, input logic expected, input logic actual);
    if (actual !== expected) begin
      $display("%0t ns: %s mismatch, expected %0b, actual %0b", $time, name, expected, actual);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ns: result item with no item outstanding", $time);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        check_bit("status", want.status, rsp.status);
        check_bit("pump_on", want.pump_on, rsp.pump_on);
        check_bit("fan_on", want.fan_on, rsp.fan_on);
        check_bit("pump_timed_out", want.pump_timed_out, rsp.pump_timed_out);
        check_bit("fan_timed_out", want.fan_timed_out, rsp.fan_timed_out);
        reports_checked++;
        rejects_seen  += want.status;
        pump_timeouts += want.pump_timed_out;
        fan_timeouts  += want.fan_timed_out;
      end
    end
  end

  // Watchdog: ends the run when no channel moves an item for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1) ||
          (cfg.valid === 1'b1 && cfg.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("%0t ns: no handshake for %0d cycles", $time, StallLimit);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    req.valid     = 1'b0;
    req.command   = CMD_PUMP;
    req.switch_on = 1'b0;
    req.now_ms    = '0;
    cfg.valid     = 1'b0;
    cfg.index     = REG_SELF_TEST;
    cfg.data      = '0;
    rst           = 1'b1;
    pump_trk        = '0;
    fan_trk         = '0;
    self_test_cfg   = 1'b0;
    auto_safety_cfg = 1'b1;
    pump_max_on_cfg = RstPumpMaxOn;
    pump_cool_cfg   = RstPumpCooldown;
    fan_max_on_cfg  = RstFanMaxOn;
    fan_cool_cfg    = RstFanCooldown;
    clock_ms        = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_defaults();
    test_edge_times();
    test_config_extremes();
    test_random_sessions();
    wait_all_results();

    $display("Sent %0d items across %0d random setting phases, %0d register writes.",
             items_sent, phase_count, cfg_writes);
    $display("Checked %0d results: %0d cooldown rejects, %0d pump and %0d fan timeouts.",
             reports_checked, rejects_seen, pump_timeouts, fan_timeouts);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
